[rtl/wphd_pkg.sv]
// Package: shared types and constants for the worker pool dispatcher.
package wphd_pkg;

  localparam int NumWorkers = 16;
  localparam int ReadyDepth = 32;
  localparam int IdW = 4;
  localparam int PtrW = 5;
  localparam int CntW = 6;
  localparam int LifeW = 8;
  localparam int TagW = 16;
  localparam logic [LifeW-1:0] LiveResetInit = 8'd13;

  typedef enum logic [2:0] {
    ACT_READY = 3'd0,
    ACT_DEATH = 3'd1,
    ACT_PONG  = 3'd2,
    ACT_REPLY = 3'd3,
    ACT_REQ   = 3'd4,
    ACT_TICK  = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    K_NONE     = 3'd0,
    K_DISPATCH = 3'd1,
    K_FORWARD  = 3'd2,
    K_PING     = 3'd3,
    K_HELD     = 3'd4,
    K_REFUSED  = 3'd5,
    K_EXPIRED  = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_POPCHK, S_DRY, S_TICK
  } state_t;

  typedef struct packed {
    logic [2:0]      action;
    logic [IdW-1:0]  worker_id;
    logic            from_inner;
    logic [TagW-1:0] request_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [IdW-1:0]  target_worker;
    logic            to_inner;
    logic [TagW-1:0] tag_out;
    logic            overflow;
    logic            last;
  } out_item_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load_in;     // capture input request
    logic do_simple;   // apply ready/death/pong/reply, emit its result
    logic refuse;      // emit refused (empty FIFO)
    logic req_start;   // note whether a held request is served first
    logic pop;         // read head of FIFO
    logic dispatch;    // emit dispatch to popped worker
    logic dry;         // no live worker left: hold or refuse
    logic tick_snap;   // snapshot ping/expiry masks, update all workers
    logic tick_emit;   // emit next tick result
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic [2:0] action;
    logic       fifo_empty;
    logic       serving;      // held request still to be dispatched
    logic       popped_live;
    logic       tick_last;    // next tick result is the final one
  } sts_t;

endpackage

[rtl/wphd_if.sv]
// Interface: valid/ready channel carrying one payload.
interface wphd_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/worker_pool_heartbeat_dispatcher_core.sv]
// Top level: worker pool dispatcher with heartbeat, controller plus datapath.
//
// Channels: "req" (sink) takes one request: action, worker_id, from_inner,
// request_tag. "res" (source) returns its results in order; the last result
// of each request has last set. A configuration write (cfg_we, cfg_data)
// sets live_reset; write it only while no request is in flight.
// Sequencing: ready/death/pong/reply/unused codes and a refused request
// (empty FIFO) are answered straight from decode. A client request pops
// the FIFO head and checks it, popping again for each stale id skipped;
// a held request is served first, then the new one from the next live
// id; finding no live worker goes through the dry state (hold or refuse).
// A tick: snapshot, then its results in order, up to 32 of them.
// Throughput: one request at a time; a new one is accepted once the
// controller is back in idle.
// Reset (rst, synchronous): worker table emptied, FIFO empty, no held
// request, live_reset back to 13. FIFO storage is not cleared.
// Stall: results sit in a one-entry output register; while it is full and
// the receiver holds ready low the controller waits, and input stalls.
module worker_pool_heartbeat_dispatcher_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  wphd_if.sink       req,
  wphd_if.source     res
);
  import wphd_pkg::*;

  cmd_t      cmd;
  sts_t      sts;
  logic      res_load, res_busy;
  out_item_t res_data;

  wphd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .out_busy(res_busy), .sts(sts), .cmd(cmd)
  );

  wphd_dp u_dp (
    .clk(clk), .rst(rst), .in_data(req.data), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .cmd(cmd), .sts(sts), .res_load(res_load),
    .res_data(res_data)
  );

  // result loads in the same edge the previous one is taken
  wphd_outq u_outq (
    .clk(clk), .rst(rst), .load(res_load), .load_data(res_data),
    .busy(res_busy), .res(res)
  );

endmodule

[rtl/wphd_ctrl.sv]
// Controller: sequences each request through decode, pops and tick results.
module wphd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_busy,
  input  wphd_pkg::sts_t   sts,
  output wphd_pkg::cmd_t   cmd
);
  import wphd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.action == ACT_TICK) begin
          cmd.tick_snap = 1'b1;
          state_next = S_TICK;
        end else if (sts.action == ACT_REQ && !sts.fifo_empty) begin
          cmd.req_start = 1'b1;
          cmd.pop = 1'b1;
          state_next = S_POPCHK;
        end else if (!out_busy) begin
          if (sts.action == ACT_REQ) cmd.refuse = 1'b1;
          else cmd.do_simple = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POPCHK: begin
        if (sts.popped_live) begin
          // dispatch needs the output slot
          if (!out_busy) begin
            cmd.dispatch = 1'b1;
            if (!sts.serving) state_next = S_IDLE;
            else if (sts.fifo_empty) state_next = S_DRY;
            else cmd.pop = 1'b1;
          end
        end else if (!sts.fifo_empty) begin
          cmd.pop = 1'b1;   // stale id, try the next one
        end else begin
          state_next = S_DRY;
        end
      end
      S_DRY: begin
        if (!out_busy) begin
          cmd.dry = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        if (!out_busy) begin
          cmd.tick_emit = 1'b1;
          if (sts.tick_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/wphd_dp.sv]
// Datapath: worker table, ready FIFO, held slot and result formatting.
module wphd_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  wphd_pkg::in_item_t      in_data,
  input  logic                    cfg_we,
  input  logic [7:0]              cfg_data,
  input  wphd_pkg::cmd_t          cmd,
  output wphd_pkg::sts_t          sts,
  output logic                    res_load,
  output wphd_pkg::out_item_t     res_data
);
  import wphd_pkg::*;

  logic [LifeW-1:0]      live_reset;
  in_item_t              cur;
  logic [NumWorkers-1:0] wvalid, winner, wping;
  logic [LifeW-1:0]      wlife [NumWorkers];
  logic [IdW-1:0]        rfifo [ReadyDepth];
  logic [PtrW-1:0]       head, tail;
  logic [CntW-1:0]       count;
  logic                  held_valid;
  logic [TagW-1:0]       held_tag;
  logic                  serving;
  logic [IdW-1:0]        popped;
  logic [NumWorkers-1:0] pmask, emask;   // pings / expiries still to report

  logic                  known, full, fifo_empty, push, ovf, plive, tick_last;
  logic [PtrW-1:0]       head_inc, tail_inc;
  logic [NumWorkers-1:0] life_low, p_rest, e_rest;
  logic [IdW-1:0]        p_idx, e_idx;

  // lowest set bit of a worker mask
  function automatic logic [IdW-1:0] low_idx(logic [NumWorkers-1:0] m);
    logic [IdW-1:0] r;
    r = '0;
    for (int i = NumWorkers - 1; i >= 0; i--) begin
      if (m[i]) r = IdW'(i);
    end
    return r;
  endfunction

  assign known = wvalid[cur.worker_id];
  assign full = (count == CntW'(ReadyDepth));
  assign fifo_empty = (count == '0);
  assign head_inc = (head == PtrW'(ReadyDepth - 1)) ? '0 : head + PtrW'(1);
  assign tail_inc = (tail == PtrW'(ReadyDepth - 1)) ? '0 : tail + PtrW'(1);
  assign plive = wvalid[popped];
  assign p_rest = pmask & (pmask - NumWorkers'(1));
  assign e_rest = emask & (emask - NumWorkers'(1));
  assign p_idx = low_idx(pmask);
  assign e_idx = low_idx(emask);

  always_comb begin
    for (int i = 0; i < NumWorkers; i++) life_low[i] = (wlife[i] <= LifeW'(1));
  end

  // pings first, then expiries; a tick with neither reports one none
  always_comb begin
    if (pmask != '0) tick_last = (p_rest == '0) && (emask == '0);
    else if (emask != '0) tick_last = (e_rest == '0);
    else tick_last = 1'b1;
  end

  always_comb begin
    push = 1'b0;
    ovf = 1'b0;
    if (cmd.do_simple &&
        ((cur.action == ACT_READY && !known) || (cur.action == ACT_REPLY && known))) begin
      push = !full;
      ovf = full;
    end
  end

  always_comb begin
    sts.action = cur.action;
    sts.fifo_empty = fifo_empty;
    sts.serving = serving;
    sts.popped_live = plive;
    sts.tick_last = tick_last;
  end

  always_comb begin
    res_load = cmd.do_simple | cmd.refuse | cmd.dispatch | cmd.dry | cmd.tick_emit;
    res_data = '0;
    res_data.last = 1'b1;
    if (cmd.do_simple) begin
      res_data.overflow = ovf;
      if (cur.action == ACT_REPLY) begin
        res_data.kind = K_FORWARD;
        res_data.target_worker = cur.worker_id;
        res_data.tag_out = cur.request_tag;
      end
    end else if (cmd.refuse) begin
      res_data.kind = K_REFUSED;
      res_data.tag_out = cur.request_tag;
    end else if (cmd.dispatch) begin
      res_data.kind = K_DISPATCH;
      res_data.target_worker = popped;
      res_data.to_inner = winner[popped];
      res_data.tag_out = serving ? held_tag : cur.request_tag;
      res_data.last = !serving;
    end else if (cmd.dry) begin
      res_data.kind = serving ? K_REFUSED : K_HELD;
      res_data.tag_out = cur.request_tag;
    end else if (cmd.tick_emit) begin
      if (pmask != '0) begin
        res_data.kind = K_PING;
        res_data.target_worker = p_idx;
        res_data.to_inner = winner[p_idx];
      end else if (emask != '0) begin
        res_data.kind = K_EXPIRED;
        res_data.target_worker = e_idx;
      end
      res_data.last = tick_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) cur <= in_data;
    if (push) rfifo[tail] <= cur.worker_id;
    if (cmd.pop) popped <= rfifo[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_reset <= LiveResetInit;
      wvalid <= '0;
      winner <= '0;
      wping <= '0;
      for (int i = 0; i < NumWorkers; i++) wlife[i] <= '0;
      head <= '0;
      tail <= '0;
      count <= '0;
      held_valid <= 1'b0;
      held_tag <= '0;
      serving <= 1'b0;
      pmask <= '0;
      emask <= '0;
    end else begin
      if (cfg_we) live_reset <= cfg_data;
      if (push) tail <= tail_inc;
      if (cmd.pop) head <= head_inc;
      count <= count + CntW'(push) - CntW'(cmd.pop);
      if (cmd.do_simple) begin
        case (cur.action)
          ACT_READY: begin
            if (!known) begin
              wvalid[cur.worker_id] <= 1'b1;
              wlife[cur.worker_id] <= live_reset;
              winner[cur.worker_id] <= cur.from_inner;
              wping[cur.worker_id] <= 1'b0;
            end
          end
          ACT_DEATH: wvalid[cur.worker_id] <= 1'b0;
          ACT_PONG: begin
            if (known) begin
              wlife[cur.worker_id] <= live_reset;
              wping[cur.worker_id] <= 1'b0;
            end
          end
          default: ;
        endcase
      end else if (cmd.tick_snap) begin
        // all workers at once; results are reported from the masks
        pmask <= wvalid & ~wping;
        emask <= wvalid & life_low;
        wvalid <= wvalid & ~life_low;
        wping <= wping | wvalid;
        for (int i = 0; i < NumWorkers; i++) begin
          if (wvalid[i]) wlife[i] <= life_low[i] ? '0 : wlife[i] - LifeW'(1);
        end
      end else if (cmd.tick_emit) begin
        if (pmask != '0) pmask <= p_rest;
        else emask <= e_rest;
      end
      if (cmd.req_start) begin
        serving <= held_valid;
      end else if (cmd.dispatch && serving) begin
        serving <= 1'b0;
        held_valid <= 1'b0;
        held_tag <= '0;
      end else if (cmd.dry) begin
        serving <= 1'b0;
        if (!serving) begin
          held_valid <= 1'b1;
          held_tag <= cur.request_tag;
        end
      end
    end
  end

endmodule

[rtl/wphd_outq.sv]
// Output stage: one-entry result register driving the result channel.
module wphd_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  wphd_pkg::out_item_t   load_data,
  output logic                  busy,
  wphd_if.source                res
);

  assign busy = res.valid && !res.ready;

  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (load) res.valid <= 1'b1;
    else if (res.ready) res.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) res.data <= load_data;
  end

endmodule

[dv/wphd_tb_if.sv]
// Bench-side note: the interface lives in rtl/wphd_if.sv; this file holds the bench's shared types.
`timescale 1ns / 1ps
package wphd_tb_pkg;
  import wphd_pkg::*;

  // Phases of sender idling and receiver stalling.
  typedef enum int {
    PH_NONE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH
  } idle_phase_t;
endpackage

[dv/worker_pool_heartbeat_dispatcher_core_tb.sv]
// Testbench: drives random and directed worker/client traffic and checks every result.
`timescale 1ns / 1ps
module worker_pool_heartbeat_dispatcher_core_tb;
  import wphd_pkg::*;
  import wphd_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'd0;

  wphd_if #(.T(in_item_t)) req ();
  wphd_if #(.T(out_item_t)) res ();

  worker_pool_heartbeat_dispatcher_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(req.sink), .res(res.source)
  );

  always #2 clk = ~clk;

  // Predictor state: a mirror of the worker table, ready FIFO and held slot.
  logic [LifeW-1:0] live_reset_q;
  logic             wk_valid [NumWorkers];
  logic [LifeW-1:0] wk_life [NumWorkers];
  logic             wk_inner [NumWorkers];
  logic             wk_pinged [NumWorkers];
  logic [IdW-1:0]   ready_ids [$];
  logic             held_q;
  logic [TagW-1:0]  held_tag_q;

  out_item_t expected_results [$];
  int mismatches = 0;
  int results_seen = 0;
  idle_phase_t phase = PH_NONE;
  bit long_hold = 1'b0;   // receiver holds off for the pressure test

  // Idle input levels before the first request.
  initial begin
    req.valid = 1'b0;
    req.data = '0;
  end

  function automatic out_item_t mk_res(kind_t k, logic [IdW-1:0] w, logic inn,
                                       logic [TagW-1:0] t, logic ovf);
    out_item_t r;
    r.kind = k;
    r.target_worker = w;
    r.to_inner = inn;
    r.tag_out = t;
    r.overflow = ovf;
    r.last = 1'b0;
    return r;
  endfunction

  // Push id; returns 1 when the FIFO is full and the id is dropped.
  function automatic logic push_ready(logic [IdW-1:0] id);
    if (ready_ids.size() >= ReadyDepth) return 1'b1;
    ready_ids.push_back(id);
    return 1'b0;
  endfunction

  // Pop until a live worker id appears; -1 when the FIFO runs dry.
  function automatic int pop_live_worker();
    logic [IdW-1:0] id;
    while (ready_ids.size() > 0) begin
      id = ready_ids[0];
      ready_ids.delete(0);
      if (wk_valid[id]) return int'(id);
    end
    return -1;
  endfunction

  task automatic reset_model();
    live_reset_q = LiveResetInit;
    for (int i = 0; i < NumWorkers; i++) begin
      wk_valid[i] = 1'b0;
      wk_life[i] = '0;
      wk_inner[i] = 1'b0;
      wk_pinged[i] = 1'b0;
    end
    ready_ids.delete();
    held_q = 1'b0;
    held_tag_q = '0;
  endtask

  // Works out the results of one accepted request and queues them.
  task automatic predict_dispatch(in_item_t it);
    out_item_t outs [$];
    logic known;
    int w;
    logic expire [NumWorkers];
    known = wk_valid[it.worker_id];
    case (it.action)
      ACT_READY: begin
        if (!known) begin
          wk_valid[it.worker_id] = 1'b1;
          wk_life[it.worker_id] = live_reset_q;
          wk_inner[it.worker_id] = it.from_inner;
          wk_pinged[it.worker_id] = 1'b0;
          outs.push_back(mk_res(K_NONE, '0, 1'b0, '0, push_ready(it.worker_id)));
        end else begin
          outs.push_back(mk_res(K_NONE, '0, 1'b0, '0, 1'b0));
        end
      end
      ACT_DEATH: begin
        if (known) wk_valid[it.worker_id] = 1'b0;
        outs.push_back(mk_res(K_NONE, '0, 1'b0, '0, 1'b0));
      end
      ACT_PONG: begin
        if (known) begin
          wk_life[it.worker_id] = live_reset_q;
          wk_pinged[it.worker_id] = 1'b0;
        end
        outs.push_back(mk_res(K_NONE, '0, 1'b0, '0, 1'b0));
      end
      ACT_REPLY: begin
        outs.push_back(mk_res(K_FORWARD, it.worker_id, 1'b0, it.request_tag,
                              known ? push_ready(it.worker_id) : 1'b0));
      end
      ACT_REQ: begin
        if (ready_ids.size() == 0) begin
          outs.push_back(mk_res(K_REFUSED, '0, 1'b0, it.request_tag, 1'b0));
        end else begin
          w = 0;
          if (held_q) begin
            w = pop_live_worker();
            if (w < 0) begin
              outs.push_back(mk_res(K_REFUSED, '0, 1'b0, it.request_tag, 1'b0));
            end else begin
              outs.push_back(mk_res(K_DISPATCH, w[IdW-1:0], wk_inner[w], held_tag_q, 1'b0));
              held_q = 1'b0;
              held_tag_q = '0;
            end
          end
          // held request still stuck: the new one was refused above
          if (w >= 0) begin
            w = pop_live_worker();
            if (w >= 0) begin
              outs.push_back(mk_res(K_DISPATCH, w[IdW-1:0], wk_inner[w], it.request_tag,
                                    1'b0));
            end else begin
              held_q = 1'b1;
              held_tag_q = it.request_tag;
              outs.push_back(mk_res(K_HELD, '0, 1'b0, it.request_tag, 1'b0));
            end
          end
        end
      end
      ACT_TICK: begin
        // pings in id order, then expiries in id order
        for (int i = 0; i < NumWorkers; i++) begin
          expire[i] = 1'b0;
          if (wk_valid[i]) begin
            if (!wk_pinged[i]) begin
              outs.push_back(mk_res(K_PING, i[IdW-1:0], wk_inner[i], '0, 1'b0));
              wk_pinged[i] = 1'b1;
            end
            if (wk_life[i] <= 1) begin
              wk_life[i] = '0;
              expire[i] = 1'b1;
            end else begin
              wk_life[i] = wk_life[i] - 1'b1;
            end
          end
        end
        for (int i = 0; i < NumWorkers; i++) begin
          if (expire[i]) begin
            wk_valid[i] = 1'b0;
            outs.push_back(mk_res(K_EXPIRED, i[IdW-1:0], 1'b0, '0, 1'b0));
          end
        end
        if (outs.size() == 0) outs.push_back(mk_res(K_NONE, '0, 1'b0, '0, 1'b0));
      end
      default: outs.push_back(mk_res(K_NONE, '0, 1'b0, '0, 1'b0));
    endcase
    outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) expected_results.push_back(outs[i]);
  endtask

  // Sender: one request, with an optional idle gap, held until accepted.
  task automatic send_msg(logic [2:0] act, logic [IdW-1:0] id, logic inn,
                          logic [TagW-1:0] tag);
    in_item_t it;
    it.action = act;
    it.worker_id = id;
    it.from_inner = inn;
    it.request_tag = tag;
    if ((phase == PH_SEND_IDLE || phase == PH_BOTH) && !long_hold) begin
      while ($urandom_range(99) < (phase == PH_BOTH ? 32 : 63)) @(negedge clk);
    end
    req.data = it;
    req.valid = 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_dispatch(it);
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  // Receiver ready pattern, changed at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (long_hold) begin
      res.ready <= 1'b0;
    end else if (phase == PH_RECV_STALL) begin
      res.ready <= ($urandom_range(99) >= 63);
    end else if (phase == PH_BOTH) begin
      res.ready <= ($urandom_range(99) >= 32);
    end else begin
      res.ready <= 1'b1;
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t got;
    out_item_t exp_r;
    if (!rst && res.valid && res.ready) begin
      got = res.data;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d worker=%0d tag=%h", got.kind,
                   got.target_worker, got.tag_out);
      end else begin
        exp_r = expected_results[0];
        expected_results.delete(0);
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp kind=%0d w=%0d in=%0d tag=%h ovf=%0d last=%0d",
                      " | got kind=%0d w=%0d in=%0d tag=%h ovf=%0d last=%0d"},
                     exp_r.kind, exp_r.target_worker, exp_r.to_inner, exp_r.tag_out,
                     exp_r.overflow, exp_r.last, got.kind, got.target_worker,
                     got.to_inner, got.tag_out, got.overflow, got.last);
        end
      end
    end
  end

  // Wait until every expected result has arrived, then let the block settle.
  task automatic drain_results();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // live_reset write while idle; the model follows at the same edge.
  task automatic write_live_reset(logic [7:0] v);
    drain_results();
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    live_reset_q = v;
  endtask

  // Every action, unknown and known workers, overflow, held and refused cases.
  task automatic test_directed();
    send_msg(ACT_REQ, 4'd0, 1'b0, 16'hFFFF);      // empty FIFO: refused
    send_msg(ACT_TICK, 4'd0, 1'b0, 16'h0000);     // no workers: one none
    send_msg(ACT_DEATH, 4'd3, 1'b1, 16'h1234);    // unknown worker
    send_msg(ACT_PONG, 4'd15, 1'b0, 16'h0001);
    send_msg(ACT_REPLY, 4'd7, 1'b1, 16'hA5A5);    // unknown: forwarded only
    send_msg(ACT_READY, 4'd0, 1'b1, 16'h0);
    send_msg(ACT_READY, 4'd15, 1'b0, 16'h0);
    send_msg(ACT_READY, 4'd0, 1'b0, 16'h0);       // known: ignored
    send_msg(3'd6, 4'd1, 1'b1, 16'hFFFF);         // unused action codes
    send_msg(3'd7, 4'd2, 1'b0, 16'h8000);
    send_msg(ACT_REQ, 4'd0, 1'b0, 16'h0101);
    send_msg(ACT_DEATH, 4'd15, 1'b0, 16'h0);      // stale entry left in FIFO
    send_msg(ACT_REQ, 4'd0, 1'b0, 16'h0202);      // stale skipped: held
    send_msg(ACT_REPLY, 4'd0, 1'b0, 16'h0303);    // requeue 0
    send_msg(ACT_READY, 4'd9, 1'b1, 16'h0);
    send_msg(ACT_REQ, 4'd0, 1'b1, 16'h0404);      // held first, then new
    send_msg(ACT_TICK, 4'd0, 1'b0, 16'h0);
    send_msg(ACT_PONG, 4'd9, 1'b1, 16'h0);
    send_msg(ACT_TICK, 4'd0, 1'b0, 16'h0);
    // fill the FIFO past its depth with replies from worker 9
    for (int i = 0; i < ReadyDepth + 2; i++) send_msg(ACT_REPLY, 4'd9, 1'b0, i[15:0]);
    send_msg(ACT_READY, 4'd4, 1'b0, 16'h0);       // valid but not queued
    drain_results();
  endtask

  // Sets live_reset to lr; a low value makes workers expire within a tick or two.
  task automatic test_expiry(logic [7:0] lr);
    write_live_reset(lr);
    for (int i = 0; i < NumWorkers; i++)
      send_msg(ACT_READY, i[IdW-1:0], 1'($urandom_range(1)), 16'h0);
    for (int i = 0; i < 3; i++) send_msg(ACT_TICK, 4'd0, 1'b0, 16'($urandom));
    drain_results();
  endtask

  // Mostly well-formed worker lifecycles with random content.
  task automatic test_random(int n);
    int r;
    logic [IdW-1:0] id;
    logic inn;
    logic [TagW-1:0] tag;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      id = IdW'($urandom_range(NumWorkers - 1));
      inn = 1'($urandom_range(1));
      tag = 16'($urandom);
      if (r < 18) send_msg(ACT_READY, id, inn, tag);
      else if (r < 26) send_msg(ACT_DEATH, id, inn, tag);
      else if (r < 40) send_msg(ACT_PONG, id, inn, tag);
      else if (r < 60) send_msg(ACT_REPLY, id, inn, tag);
      else if (r < 86) send_msg(ACT_REQ, id, inn, tag);
      else if (r < 97) send_msg(ACT_TICK, id, inn, tag);
      else send_msg(3'($urandom_range(7, 6)), id, inn, tag);
    end
  endtask

  // Receiver holds off while ticks and requests keep coming; input must stall.
  task automatic test_backpressure();
    int hold_cycles;
    for (int i = 0; i < 6; i++) send_msg(ACT_READY, i[IdW-1:0], i[0], 16'h0);
    long_hold = 1'b1;
    fork
      begin
        hold_cycles = 0;
        while (hold_cycles < 300) begin
          @(negedge clk);
          hold_cycles++;
        end
        long_hold = 1'b0;
      end
      for (int i = 0; i < 8; i++)
        send_msg(i[0] ? ACT_TICK : ACT_REQ, 4'd0, 1'b0, 16'($urandom));
    join
    drain_results();
  endtask

  initial begin
    reset_model();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    phase = PH_NONE;
    test_directed();
    test_expiry(8'd1);
    test_expiry(8'd255);
    test_backpressure();
    write_live_reset(8'd4);
    phase = PH_NONE;        test_random(70);
    phase = PH_SEND_IDLE;   test_random(70);
    write_live_reset(8'd2);
    phase = PH_RECV_STALL;  test_random(70);
    write_live_reset(8'd13);
    phase = PH_BOTH;        test_random(70);
    phase = PH_NONE;
    drain_results();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
